// ===== hw/rtl/bdhe_pkg.sv =====
package bdhe_pkg;

  // Number of buttons that keep a phase counter.
  localparam int NUM_BUTTONS = 64;
  localparam int IDX_W       = $clog2(NUM_BUTTONS);

  // Counter and configuration widths.
  localparam int CNT_W = 18;
  localparam int DB_W  = 10;
  localparam int HD_W  = 16;

  // Reset values of the configuration registers.
  localparam logic [DB_W-1:0] DEBOUNCE_RESET = DB_W'(10);
  localparam logic [HD_W-1:0] HOLD_RESET     = HD_W'(300);

  // Configuration register indexes.
  localparam logic CFG_DEBOUNCE = 1'b0;
  localparam logic CFG_HOLD     = 1'b1;

  // Edge modes of a button mapping.
  localparam logic [2:0] EDGE_RELEASE  = 3'd0;
  localparam logic [2:0] EDGE_PRESS    = 3'd1;
  localparam logic [2:0] EDGE_HOLD     = 3'd2;
  localparam logic [2:0] EDGE_SH_PRESS = 3'd3;
  localparam logic [2:0] EDGE_SH_HOLD  = 3'd4;

  // Event kinds.
  localparam logic [1:0] KIND_PRESS   = 2'd0;
  localparam logic [1:0] KIND_HOLD    = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  typedef logic signed [CNT_W-1:0] cnt_t;

  // Listed from the highest bit down, so the struct matches in_tdata[11:6].
  typedef struct packed {
    logic       shift_active;
    logic       repeat_on_hold;
    logic [2:0] edge_mode;
    logic       pressed;
  } sample_t;

  typedef struct packed {
    logic       event_valid;
    logic [1:0] event_kind;
  } event_t;

endpackage

// ===== hw/rtl/bdhe_step.sv =====
// Phase update of one button: the phases are tested in a fixed priority order.
module bdhe_step (
  input  bdhe_pkg::cnt_t                  cnt_i,
  input  bdhe_pkg::sample_t               smp_i,
  input  logic [bdhe_pkg::DB_W-1:0]       debounce_i,
  input  logic [bdhe_pkg::HD_W-1:0]       hold_i,
  output bdhe_pkg::cnt_t                  cnt_o,
  output bdhe_pkg::event_t                evt_o
);

  bdhe_pkg::cnt_t db_s;
  bdhe_pkg::cnt_t hd_s;
  bdhe_pkg::cnt_t cnt_inc;
  logic           hold_ok;
  logic           press_ok;
  logic           release_ok;

  assign db_s    = {{(bdhe_pkg::CNT_W - bdhe_pkg::DB_W){1'b0}}, debounce_i};
  assign hd_s    = {{(bdhe_pkg::CNT_W - bdhe_pkg::HD_W){1'b0}}, hold_i};
  assign cnt_inc = cnt_i + bdhe_pkg::cnt_t'(1);

  assign hold_ok  = (!smp_i.shift_active && smp_i.edge_mode == bdhe_pkg::EDGE_HOLD) ||
                    (smp_i.shift_active && smp_i.edge_mode == bdhe_pkg::EDGE_SH_HOLD);
  assign press_ok = (!smp_i.shift_active && smp_i.edge_mode == bdhe_pkg::EDGE_PRESS) ||
                    (smp_i.shift_active && smp_i.edge_mode == bdhe_pkg::EDGE_SH_PRESS);
  assign release_ok = (smp_i.edge_mode == bdhe_pkg::EDGE_RELEASE);

  always_comb begin
    cnt_o             = cnt_i;
    evt_o.event_valid = 1'b0;
    evt_o.event_kind  = bdhe_pkg::KIND_PRESS;
    if (cnt_i == '0) begin
      // Idle: a pressed level starts the press debounce.
      if (smp_i.pressed) begin
        if (press_ok) begin
          evt_o.event_valid = 1'b1;
          evt_o.event_kind  = bdhe_pkg::KIND_PRESS;
        end
        cnt_o = bdhe_pkg::cnt_t'(1);
      end
    end else if (cnt_i > bdhe_pkg::cnt_t'(0) && cnt_i < db_s) begin
      cnt_o = cnt_inc;
    end else if (cnt_i >= db_s && cnt_i < hd_s) begin
      if (!smp_i.pressed) begin
        if (release_ok) begin
          evt_o.event_valid = 1'b1;
          evt_o.event_kind  = bdhe_pkg::KIND_RELEASE;
        end
        cnt_o = -db_s;
      end else begin
        cnt_o = cnt_inc;
      end
    end else if (cnt_i == hd_s) begin
      // Hold is reached whatever the level.
      if (hold_ok) begin
        evt_o.event_valid = 1'b1;
        evt_o.event_kind  = bdhe_pkg::KIND_HOLD;
      end
      cnt_o = cnt_inc;
    end else if (cnt_i > hd_s) begin
      if (smp_i.pressed) begin
        if (smp_i.repeat_on_hold && hold_ok) begin
          evt_o.event_valid = 1'b1;
          evt_o.event_kind  = bdhe_pkg::KIND_HOLD;
        end
      end else begin
        if (release_ok) begin
          evt_o.event_valid = 1'b1;
          evt_o.event_kind  = bdhe_pkg::KIND_RELEASE;
        end
        cnt_o = -db_s;
      end
    end else begin
      // Release debounce counts back up to idle.
      cnt_o = cnt_inc;
    end
  end

endmodule

// ===== hw/rtl/button_debounce_hold_events.sv =====
// Button debounce with press, release, hold and hold-repeat events.
//
// The in_ channel takes one sampled level of one button per word, together
// with that button's edge mode, repeat flag and the shift state. Every input
// word yields exactly one output word on the out_ channel, in order, which
// says whether an event fires, of which kind, and for which button.
// The cfg_ channel writes the debounce and hold tick counts; it is always
// ready and should only be used while no word is in flight.
//
// A word is registered in stage one, then in the output register; while the
// receiver does not stall, the block sustains one word per cycle. The
// per-button counters sit in a 64-entry memory with a registered read: a word
// reads its counter in the accept cycle and writes the updated value as it
// moves to the output register; a following word for the same button takes the new value through a bypass.
//
// Reset empties the pipeline, loads the register defaults and marks every
// counter as idle through one valid flag per entry, so no clearing pass is
// needed. When the receiver stalls, the output register holds its word, the
// update stage holds behind it, and in_tready drops only once both are full.
module button_debounce_hold_events (
  input  logic        clk,
  input  logic        rst_n,
  // Input: [5:0] button_index, [6] pressed, [9:7] edge_mode,
  // [10] repeat_on_hold, [11] shift_active, [15:12] zero.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,
  // Output: [0] event_valid, [2:1] event_kind, [8:3] event_button,
  // [15:9] zero.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  // Configuration: index 0 debounce_ticks (data [9:0]), 1 hold_ticks.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int NB = bdhe_pkg::NUM_BUTTONS;
  localparam int IW = bdhe_pkg::IDX_W;

  // Configuration registers.
  logic [bdhe_pkg::DB_W-1:0] debounce_r;
  logic [bdhe_pkg::HD_W-1:0] hold_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= bdhe_pkg::DEBOUNCE_RESET;
      hold_r     <= bdhe_pkg::HOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bdhe_pkg::CFG_DEBOUNCE: debounce_r <= cfg_data[bdhe_pkg::DB_W-1:0];
        bdhe_pkg::CFG_HOLD:     hold_r     <= cfg_data[bdhe_pkg::HD_W-1:0];
        default:                ;
      endcase
    end
  end

  // Input word fields.
  logic [IW-1:0]     in_idx;
  bdhe_pkg::sample_t in_smp;

  assign in_idx = in_tdata[IW-1:0];
  assign in_smp = in_tdata[11:6];

  // Pipeline control. Stage one holds the word whose counter was read.
  logic s1_valid_r;
  logic out_valid_r;
  logic adv;
  logic in_acc;
  logic wr_en;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;
  assign wr_en     = s1_valid_r && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Stage one payload.
  logic [IW-1:0]     s1_idx_r;
  bdhe_pkg::sample_t s1_smp_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_idx_r <= in_idx;
      s1_smp_r <= in_smp;
    end
  end

  // Counter memory, one entry per button, read in the accept cycle.
  logic [bdhe_pkg::CNT_W-1:0] mem [NB];
  logic [bdhe_pkg::CNT_W-1:0] rd_data_r;
  bdhe_pkg::cnt_t             wr_cnt;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data_r <= mem[in_idx];
    end
    if (wr_en) begin
      mem[s1_idx_r] <= wr_cnt;
    end
  end

  // Entries never written since reset read as idle.
  logic [NB-1:0] vld_r;
  logic          rd_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[s1_idx_r] <= 1'b1;
    end
  end

  // Bypass: the memory read sees the old value when the same entry is
  // written at the same edge, so the written value is captured instead.
  logic           fwd_hit_r;
  bdhe_pkg::cnt_t fwd_cnt_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_vld_r  <= vld_r[in_idx];
      fwd_hit_r <= wr_en && (s1_idx_r == in_idx);
      fwd_cnt_r <= wr_cnt;
    end
  end

  bdhe_pkg::cnt_t cur_cnt;

  always_comb begin
    if (fwd_hit_r) begin
      cur_cnt = fwd_cnt_r;
    end else if (rd_vld_r) begin
      cur_cnt = rd_data_r;
    end else begin
      cur_cnt = '0;
    end
  end

  bdhe_pkg::event_t s1_evt;

  bdhe_step u_step (
    .cnt_i      (cur_cnt),
    .smp_i      (s1_smp_r),
    .debounce_i (debounce_r),
    .hold_i     (hold_r),
    .cnt_o      (wr_cnt),
    .evt_o      (s1_evt)
  );

  // Output register.
  bdhe_pkg::event_t out_evt_r;
  logic [IW-1:0]    out_idx_r;

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      out_evt_r <= s1_evt;
      out_idx_r <= s1_idx_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_idx_r, out_evt_r.event_kind, out_evt_r.event_valid};

  // Only the three defined event kinds are produced.
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_evt_r.event_kind != 2'd3)
    else $error("illegal event kind");

  // A word without an event carries kind zero.
  a_quiet_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_evt_r.event_valid) |-> out_evt_r.event_kind == bdhe_pkg::KIND_PRESS)
    else $error("event kind set without event");

  // A stalled update stage must not write its counter.
  a_no_write_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_tready) |-> !wr_en)
    else $error("counter written while stalled");

  // A counter write marks its entry as valid.
  a_valid_set: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> vld_r[$past(s1_idx_r)])
    else $error("written entry not marked valid");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!s1_valid_r && !out_valid_r))
    else $error("pipeline not empty after reset");

endmodule

// ===== test/tb_button_debounce_hold_events.sv =====
module tb_button_debounce_hold_events;
  import bdhe_pkg::*;

  // Longest run allowed before the watchdog gives up, in clock cycles.
  localparam int LIMIT_CYCLES = 200000;
  localparam int PERIOD       = 8;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // [5:0] button_index, [6] pressed, [9:7] edge_mode, [10] repeat_on_hold,
  // [11] shift_active, [15:12] zero.
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  // [0] event_valid, [2:1] event_kind, [8:3] event_button, [15:9] zero.
  logic [15:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;

  // When set, neither the sender nor the receiver inserts any idle cycles.
  bit no_idle = 1'b0;

  button_debounce_hold_events u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #(PERIOD / 2) clk = ~clk;

  // One expected output word: the event flags plus the button it belongs to.
  typedef struct {
    event_t     ev;
    logic [5:0] button;
  } event_word_t;

  // The scoreboard keeps its own copy of the debounce registers and of every
  // button's phase counter. Each accepted sample is run through the phase
  // rules right away, and the resulting event word is queued until the block
  // delivers its answer, which must come back in the same order.
  class event_board;
    logic [DB_W-1:0] debounce_ticks;
    logic [HD_W-1:0] hold_ticks;
    cnt_t            phase_cnt [NUM_BUTTONS];
    event_word_t     pending_events [$];
    int              wrong_words;
    int              words_checked;
    int              kind_seen [3];

    function new();
      debounce_ticks = DEBOUNCE_RESET;
      hold_ticks     = HOLD_RESET;
      foreach (phase_cnt[i]) phase_cnt[i] = '0;
      wrong_words    = 0;
      words_checked  = 0;
      kind_seen      = '{0, 0, 0};
    endfunction

    function void write_reg(logic index, logic [15:0] data);
      if (index == CFG_DEBOUNCE) debounce_ticks = data[DB_W-1:0];
      else hold_ticks = data[HD_W-1:0];
    endfunction

    // Advances the button's counter by one scan tick and queues the event
    // word that the tick should produce. The phases are tried in a fixed
    // order, so a counter that ends its debounce already above the hold threshold
    // counts as held even if the hold tick itself was never seen.
    function void predict_sample(logic [15:0] word);
      logic [5:0] idx;
      logic       lvl;
      logic [2:0] mode;
      logic       rpt;
      logic       shf;
      int         d;
      int         db;
      int         hd;
      bit         hold_ok;
      event_t     ev;
      idx  = word[5:0];
      lvl  = word[6];
      mode = word[9:7];
      rpt  = word[10];
      shf  = word[11];
      ev   = '0;
      if (idx < NUM_BUTTONS) begin
        d       = int'(phase_cnt[idx]);
        db      = int'(debounce_ticks);
        hd      = int'(hold_ticks);
        hold_ok = (!shf && mode == EDGE_HOLD) || (shf && mode == EDGE_SH_HOLD);
        if (d == 0) begin
          if (lvl) begin
            if ((!shf && mode == EDGE_PRESS) || (shf && mode == EDGE_SH_PRESS))
              ev = '{1'b1, KIND_PRESS};
            d = 1;
          end
        end else if (d > 0 && d < db) begin
          d++;
        end else if (d >= db && d < hd) begin
          if (!lvl) begin
            if (mode == EDGE_RELEASE) ev = '{1'b1, KIND_RELEASE};
            d = -db;
          end else begin
            d++;
          end
        end else if (d == hd) begin
          if (hold_ok) ev = '{1'b1, KIND_HOLD};
          d++;
        end else if (d > hd) begin
          if (lvl) begin
            if (rpt && hold_ok) ev = '{1'b1, KIND_HOLD};
          end else begin
            if (mode == EDGE_RELEASE) ev = '{1'b1, KIND_RELEASE};
            d = -db;
          end
        end else if (d < 0) begin
          d++;
        end
        phase_cnt[idx] = cnt_t'(d);
      end
      pending_events.push_back('{ev, idx});
    endfunction

    function void check_result(logic [15:0] word);
      event_word_t want;
      logic        got_valid;
      logic [1:0]  got_kind;
      logic [5:0]  got_btn;
      got_valid = word[0];
      got_kind  = word[2:1];
      got_btn   = word[8:3];
      words_checked++;
      if (got_valid && got_kind <= KIND_RELEASE) kind_seen[got_kind]++;
      if (pending_events.size() == 0) begin
        wrong_words++;
        if (wrong_words <= 10)
          $display("%0t: output word %h arrived with no sample waiting for it", $time, word);
        return;
      end
      want = pending_events.pop_front();
      if (got_valid !== want.ev.event_valid || got_kind !== want.ev.event_kind ||
          got_btn !== want.button || word[15:9] !== 7'd0) begin
        wrong_words++;
        if (wrong_words <= 10)
          $display("%0t: wrong event word: expected valid %0b kind %0d button %0d, got %h",
                   $time, want.ev.event_valid, want.ev.event_kind, want.button, word);
      end
    endfunction
  endclass

  event_board board = new();
  int         cfg_writes = 0;

  // Each side idles at random roughly 13 percent of the time, except while the
  // no-idle stretch is running.
  function automatic bit take_gap();
    return !no_idle && ($urandom_range(0, 99) < 13);
  endfunction

  function automatic logic [15:0] pack_sample(logic [5:0] idx, logic lvl, logic [2:0] mode,
                                              logic rpt, logic shf);
    return {4'b0, shf, rpt, mode, lvl, idx};
  endfunction

  // The receiver stalls at random. Its ready changes on the falling edge only.
  always @(negedge clk) out_tready <= rst_n && !take_gap();

  // Every word the block hands over is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
  end

  // Called on a falling edge; returns on the falling edge after acceptance
  // with tvalid still high, so back-to-back words never drop it.
  task automatic send_sample(input logic [15:0] word);
    while (take_gap()) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    board.predict_sample(word);
    @(negedge clk);
  endtask

  // Stops sending and waits until every queued prediction has been answered.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (board.pending_events.size() != 0);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic write_cfg(input logic index, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(index, data);
    cfg_writes++;
    @(negedge clk);
  endtask

  // Random scan traffic. A few buttons play out press and release runs, some
  // long enough to pass through debounce and reach hold, each run with a
  // mapping of its own. Some samples stray from the run's mapping or shift
  // state, and about one in eight is plain noise on any button.
  task automatic run_random(input int count, input int slots, input int drain_at);
    logic [5:0] btn [4];
    logic [2:0] mode [4];
    logic       rpt [4];
    logic       shf [4];
    logic       lvl [4];
    int         left [4];
    int         k;
    int         span;
    logic [2:0] m;
    logic       s;
    for (k = 0; k < 4; k++) begin
      btn[k]  = 6'($urandom_range(0, 63));
      mode[k] = EDGE_RELEASE;
      rpt[k]  = 1'b0;
      shf[k]  = 1'b0;
      lvl[k]  = 1'b0;
      left[k] = 0;
    end
    for (int i = 0; i < count; i++) begin
      if (i == drain_at) drain();
      if ($urandom_range(0, 99) < 12) begin
        send_sample({4'b0, 12'($urandom)});
      end else begin
        k = $urandom_range(0, slots - 1);
        if (left[k] == 0) begin
          lvl[k] = !lvl[k];
          if (lvl[k]) begin
            mode[k] = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                  : 3'($urandom_range(0, 4));
            rpt[k]  = 1'($urandom_range(0, 1));
            if (mode[k] == EDGE_SH_PRESS || mode[k] == EDGE_SH_HOLD)
              shf[k] = ($urandom_range(0, 4) != 0);
            else
              shf[k] = ($urandom_range(0, 4) == 0);
            span = int'(board.hold_ticks) + 4;
            if (span > 40) span = 40;
          end else begin
            span = int'(board.debounce_ticks) + 3;
            if (span > 12) span = 12;
          end
          left[k] = $urandom_range(1, span);
        end
        left[k]--;
        m = mode[k];
        s = shf[k];
        if ($urandom_range(0, 9) == 0) m = 3'($urandom_range(0, 4));
        if ($urandom_range(0, 9) == 0) s = !s;
        send_sample(pack_sample(btn[k], lvl[k], m, rpt[k], s));
      end
    end
  endtask

  initial begin
    // Register settings for the random phases: short and zero debounce, hold
    // below debounce, the largest values of both, and a longer hold.
    int phase_db [8]    = '{2, 1, 0, 5, 3, 1, 1023, 4};
    int phase_hd [8]    = '{6, 4, 3, 3, 12, 2, 65535, 30};
    int phase_len [8]   = '{130, 130, 110, 110, 130, 100, 60, 180};
    int phase_slots [8] = '{3, 4, 3, 3, 2, 4, 4, 1};

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_DEBOUNCE;
    cfg_data   = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Default registers: a plain press, a shifted press on the top button,
    // a press mapping with shift on, an unused edge mode, and a release
    // sample on an idle button.
    send_sample(pack_sample(6'd0, 1'b1, EDGE_PRESS, 1'b0, 1'b0));
    send_sample(pack_sample(6'd63, 1'b1, EDGE_SH_PRESS, 1'b1, 1'b1));
    send_sample(pack_sample(6'd1, 1'b1, EDGE_PRESS, 1'b0, 1'b1));
    send_sample(pack_sample(6'd2, 1'b1, 3'd7, 1'b1, 1'b0));
    send_sample(pack_sample(6'd3, 1'b0, EDGE_RELEASE, 1'b0, 1'b0));
    drain();

    // Short debounce and hold so that one button walks through every phase.
    write_cfg(CFG_DEBOUNCE, 16'd1);
    write_cfg(CFG_HOLD, 16'd3);
    cfg_valid <= 1'b0;
    // Press, pressed, hold, hold repeat (plain and shifted), no repeat,
    // unused mode while held, release, then back to idle.
    send_sample(pack_sample(6'd10, 1'b1, EDGE_PRESS, 1'b0, 1'b0));
    send_sample(pack_sample(6'd10, 1'b1, EDGE_RELEASE, 1'b0, 1'b0));
    send_sample(pack_sample(6'd10, 1'b1, EDGE_HOLD, 1'b0, 1'b0));
    send_sample(pack_sample(6'd10, 1'b1, EDGE_HOLD, 1'b0, 1'b0));
    send_sample(pack_sample(6'd10, 1'b1, EDGE_HOLD, 1'b1, 1'b0));
    send_sample(pack_sample(6'd10, 1'b1, EDGE_SH_HOLD, 1'b1, 1'b1));
    send_sample(pack_sample(6'd10, 1'b1, EDGE_HOLD, 1'b0, 1'b0));
    send_sample(pack_sample(6'd10, 1'b1, 3'd5, 1'b1, 1'b0));
    send_sample(pack_sample(6'd10, 1'b0, EDGE_RELEASE, 1'b0, 1'b0));
    send_sample(pack_sample(6'd10, 1'b0, EDGE_RELEASE, 1'b0, 1'b0));
    // Release from the pressed phase, with shift on, then release debounce.
    send_sample(pack_sample(6'd11, 1'b1, EDGE_PRESS, 1'b0, 1'b0));
    send_sample(pack_sample(6'd11, 1'b1, EDGE_PRESS, 1'b0, 1'b0));
    send_sample(pack_sample(6'd11, 1'b0, EDGE_RELEASE, 1'b0, 1'b1));
    send_sample(pack_sample(6'd11, 1'b1, EDGE_PRESS, 1'b0, 1'b0));
    // Shifted hold, then a release sample whose mapping does not fire.
    send_sample(pack_sample(6'd12, 1'b1, EDGE_PRESS, 1'b0, 1'b0));
    send_sample(pack_sample(6'd12, 1'b1, EDGE_PRESS, 1'b0, 1'b0));
    send_sample(pack_sample(6'd12, 1'b1, EDGE_PRESS, 1'b0, 1'b0));
    send_sample(pack_sample(6'd12, 1'b1, EDGE_SH_HOLD, 1'b0, 1'b1));
    send_sample(pack_sample(6'd12, 1'b0, EDGE_SH_PRESS, 1'b0, 1'b0));

    // Random phases. Registers change only once the block has gone quiet;
    // the counters carry over, so some buttons see a setting change mid-count.
    // The first phase also stops once in the middle until everything is back,
    // and the second runs with no idle cycles on either side.
    for (int p = 0; p < 8; p++) begin
      drain();
      write_cfg(CFG_DEBOUNCE, {6'($urandom), 10'(phase_db[p])});
      write_cfg(CFG_HOLD, 16'(phase_hd[p]));
      cfg_valid <= 1'b0;
      no_idle = (p == 1);
      run_random(phase_len[p], phase_slots[p], (p == 0) ? phase_len[p] / 2 : -1);
    end
    no_idle = 1'b0;

    drain();
    repeat (8) @(posedge clk);
    $display("Run covered %0d output words over %0d register writes and 10 settings.",
             board.words_checked, cfg_writes);
    $display("Events seen: %0d press, %0d hold, %0d release; %0d wrong words.",
             board.kind_seen[0], board.kind_seen[1], board.kind_seen[2], board.wrong_words);
    if (board.wrong_words == 0 && board.pending_events.size() == 0) begin
      $display("button_debounce_hold_events: match");
    end else begin
      $display("button_debounce_hold_events: mismatch");
    end
    $finish;
  end

  // Watchdog for a block that stops answering or never takes a word.
  initial begin
    #(LIMIT_CYCLES * PERIOD);
    $display("Timed out with %0d predictions outstanding.", board.pending_events.size());
    $display("button_debounce_hold_events: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/bdhe_pkg.sv
hw/rtl/bdhe_step.sv
hw/rtl/button_debounce_hold_events.sv
test/tb_button_debounce_hold_events.sv
